[rtl/core/kts_pkg.sv]
// Shared widths and constants of the Kendall tau series block.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

    // Default sizing of the block.
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_SUM_W = 16;
    localparam int COUNT_W    = 9;
    localparam int TAU_W      = 16;
    localparam int MEAN_W     = 16;

    // Tau is a signed Q1.15 fraction.
    localparam int Q_FRAC = 15;
    localparam logic [TAU_W-1:0] TAU_MAX = {1'b0, {(TAU_W-1){1'b1}}};

endpackage

`default_nettype wire

[rtl/core/kts_chan_if.sv]
// Request and result channel interfaces of the Kendall tau series block.
`timescale 1ns / 1ps
`default_nettype none

interface kts_in_if
    import kts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface kts_out_if
    import kts_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [PAIR_SUM_W-1:0] pair_sum;
    logic [COUNT_W-1:0]           sample_count;
    logic signed [TAU_W-1:0]      tau;
    logic                         tau_valid;
    logic [MEAN_W-1:0]            mean_value;
    logic                         mean_valid;
    logic                         overflow;

    modport source (
        output valid, output pair_sum, output sample_count, output tau,
        output tau_valid, output mean_value, output mean_valid, output overflow,
        input ready
    );
    modport sink (
        input valid, input pair_sum, input sample_count, input tau,
        input tau_valid, input mean_value, input mean_valid, input overflow,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/kts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/kts_div.sv]
// Radix-2 restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module kts_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0]      o_quotient,
    output logic                       o_done
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  n_rem;

    // The partial remainder stays below the divisor, so the shifted trial
    // value needs one extra bit only.
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(DIVIDEND_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

[rtl/core/kendall_tau_series.sv]
// Top level of the Kendall tau-a series block with sample store and divider.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+------------------------------------------
//  i_in    | sink      | valid / ready     | sample, last
//  o_out   | source    | valid / ready     | pair_sum, sample_count, tau, tau_valid,
//          |           |                   | mean_value, mean_valid, overflow
//
// A request that finds n samples stored is accepted and its sample written, then the n
// stored entries are read at one per cycle, and the read latency and the last compare
// close the scan. A dropped sample is only accepted. The last request of a series adds
// the pair count, two passes of the shared divider (tau, then the mean), and the load
// of the output register.
// Reset needs no clearing pass: only entries written in the current series are read.
// A finished result waits in the output register while the next series starts; the
// block stalls only when a second result is ready before the first was taken.
`timescale 1ns / 1ps
`default_nettype none

module kendall_tau_series
    import kts_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kts_in_if.sink    i_in,
    kts_out_if.source o_out
);

    // Sizing that follows from the store depth and the sample width.
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int AW        = $clog2(MAX_SAMPLES);
    localparam int PAIRS_MAX = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
    localparam int P_W       = $clog2(PAIRS_MAX + 1);
    localparam int ST_W      = P_W + 1;
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int VW        = (P_W > CNT_W) ? P_W : CNT_W;
    localparam int TAU_DW    = P_W + Q_FRAC;
    localparam int DW        = (TAU_DW > SUM_W) ? TAU_DW : SUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PAIRS,
        S_TAU_DIV,
        S_MEAN_DIV,
        S_FIN
    } t_state;

    t_state                  r_state;

    // Series state.
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum;
    logic signed [ST_W-1:0]  r_sign;
    logic                    r_drop;

    // Current request and the scan over the store.
    logic [SAMPLE_BITS-1:0]  r_x;
    logic                    r_last;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_limit;
    logic                    r_cmp_vld;

    // End of series arithmetic.
    logic [P_W-1:0]          r_pairs;
    logic [P_W-1:0]          r_mag;
    logic                    r_neg;
    logic [TAU_W-1:0]        r_tau;
    logic [MEAN_W-1:0]       r_mean;
    logic                    r_div_start;

    // Output register.
    logic                    r_out_valid;
    logic [PAIR_SUM_W-1:0]   r_o_pair;
    logic [COUNT_W-1:0]      r_o_count;
    logic [TAU_W-1:0]        r_o_tau;
    logic                    r_o_tau_valid;
    logic [MEAN_W-1:0]       r_o_mean;
    logic                    r_o_mean_valid;
    logic                    r_o_overflow;

    logic                    accept;
    logic                    full;
    logic [SAMPLE_BITS-1:0]  x_in;
    logic                    wr_en;
    logic                    rd_en;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic [2*CNT_W-1:0]      prod;
    logic [P_W-1:0]          mag;
    logic [DW-1:0]           div_dividend;
    logic [VW-1:0]           div_divisor;
    logic [DW-1:0]           div_quo;
    logic                    div_done;
    logic                    div_go;
    logic                    load_out;
    logic [TAU_W-1:0]        tau_q;
    logic                    has_two;
    logic                    has_one;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);
    assign full       = (r_count == CNT_W'(MAX_SAMPLES));
    assign x_in       = SAMPLE_BITS'(i_in.sample);

    // The new sample goes to the first free entry at acceptance; the scan then
    // reads only the entries below it, so writes and reads never meet.
    assign wr_en = accept && !full;
    assign rd_en = (r_state == S_SCAN) && (r_idx < r_limit);

    kts_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (x_in),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Number of unordered pairs, n(n-1)/2. When n is below two the value is
    // meaningless and tau is forced to zero later.
    assign prod = (2*CNT_W)'(r_count) * (2*CNT_W)'(r_count - CNT_W'(1));
    assign mag  = r_sign[ST_W-1] ? P_W'(-r_sign) : P_W'(r_sign);

    // One divider serves both quotients: first |pair sum| * 2^15 / pairs,
    // then the running sum over the sample count.
    always_comb begin
        if (r_state == S_TAU_DIV) begin
            div_dividend = DW'({r_mag, {Q_FRAC{1'b0}}});
            div_divisor  = VW'(r_pairs);
        end else begin
            div_dividend = DW'(r_sum);
            div_divisor  = VW'(r_count);
        end
    end

    kts_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // The magnitude quotient never exceeds 2^15, which only a tau of exactly
    // one reaches; that case saturates on the positive side.
    assign tau_q   = div_quo[TAU_W-1:0];
    assign has_two = (r_count >= CNT_W'(2));
    assign has_one = (r_count != '0);

    // The tau pass starts right after the pair count, the mean pass as soon as
    // the tau pass is done. The summary loads once the output register is free.
    assign div_go   = (r_state == S_PAIRS) || ((r_state == S_TAU_DIV) && div_done);
    assign load_out = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sign      <= '0;
            r_drop      <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= div_go;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x       <= x_in;
                        r_last    <= i_in.last;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                            r_sum   <= r_sum + SUM_W'(x_in);
                            r_limit <= r_count;
                            r_state <= S_SCAN;
                        end else begin
                            r_drop  <= 1'b1;
                            r_state <= i_in.last ? S_PAIRS : S_IDLE;
                        end
                    end
                end

                S_SCAN: begin
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    r_cmp_vld <= rd_en;
                    if (r_cmp_vld) begin
                        if (rd_data < r_x) begin
                            r_sign <= r_sign + ST_W'(1);
                        end else if (rd_data > r_x) begin
                            r_sign <= r_sign - ST_W'(1);
                        end
                    end
                    // The last compare happens in the cycle after the last read.
                    if (!rd_en) begin
                        r_state <= r_last ? S_PAIRS : S_IDLE;
                    end
                end

                S_PAIRS: begin
                    r_pairs <= P_W'(prod >> 1);
                    r_mag   <= mag;
                    r_neg   <= r_sign[ST_W-1];
                    r_state <= S_TAU_DIV;
                end

                S_TAU_DIV: begin
                    if (div_done) begin
                        if (!has_two) begin
                            r_tau <= '0;
                        end else if (r_neg) begin
                            r_tau <= TAU_W'(0) - tau_q;
                        end else begin
                            r_tau <= tau_q[TAU_W-1] ? TAU_MAX : tau_q;
                        end
                        r_state <= S_MEAN_DIV;
                    end
                end

                S_MEAN_DIV: begin
                    if (div_done) begin
                        r_mean  <= has_one ? div_quo[MEAN_W-1:0] : '0;
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (load_out) begin
                        r_o_pair       <= PAIR_SUM_W'(r_sign);
                        r_o_count      <= COUNT_W'(r_count);
                        r_o_tau        <= r_tau;
                        r_o_tau_valid  <= has_two;
                        r_o_mean       <= r_mean;
                        r_o_mean_valid <= has_one;
                        r_o_overflow   <= r_drop;
                        r_count        <= '0;
                        r_sum          <= '0;
                        r_sign         <= '0;
                        r_drop         <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pair_sum     = r_o_pair;
    assign o_out.sample_count = r_o_count;
    assign o_out.tau          = r_o_tau;
    assign o_out.tau_valid    = r_o_tau_valid;
    assign o_out.mean_value   = r_o_mean;
    assign o_out.mean_valid   = r_o_mean_valid;
    assign o_out.overflow     = r_o_overflow;

endmodule

`default_nettype wire
